// ===== src/life_pkg.sv =====
// ----------------------------------------------------------------------------
// life_pkg
// Shared constants for the toroidal Life grid: transaction codes, field
// widths, default grid size and the live count ceiling.
// ----------------------------------------------------------------------------
package life_pkg;

  // Field widths of the item ports
  localparam int FUNC_W  = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int COUNT_W = 13;

  // Function codes carried by in_func
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Default grid size
  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;

  // Reported live count saturates here
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

endpackage

// ===== src/life_automaton_toroidal_grid.sv =====
// ----------------------------------------------------------------------------
// life_automaton_toroidal_grid
// Conway Life (B3/S23) on a wrapping GRID_ROWS x GRID_COLS grid held in two
// row-wide memories, with single cell write/read and generation step.
// ----------------------------------------------------------------------------
// Each memory word is one grid row, so one buffer holds the current generation
// and the other receives the next. After reset the block runs a clearing pass
// (one row per cycle) before in_ready first rises. An in-grid cell write or
// read has its row read from memory at the accepting edge, then modified (or
// bit selected) in S_CELL, and the output register is loaded from S_DONE. In a
// step the whole next row is formed at once from a three-row window, but its
// live cells are counted one bit per cycle from a shift register, so the
// per-row count takes most of the step. Every transaction yields one result;
// the block takes a new transaction while an earlier result still waits in the
// output register, and stalls only once a second result is ready.
module life_automaton_toroidal_grid #(
  parameter int GRID_ROWS = life_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = life_pkg::DEF_GRID_COLS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [life_pkg::FUNC_W-1:0]  in_func,
  input  logic [life_pkg::ROW_W-1:0]   in_row,
  input  logic [life_pkg::COL_W-1:0]   in_col,
  input  logic                         in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_cell_value,
  output logic [life_pkg::COUNT_W-1:0] out_live_count
);

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int CNT_W = $clog2(GRID_ROWS * GRID_COLS + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CELL  = 7'b0000100,
    S_FILL  = 7'b0001000,
    S_CALC  = 7'b0010000,
    S_COUNT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Grid memories, one row per word
  logic [GRID_COLS-1:0] mem0 [GRID_ROWS];
  logic [GRID_COLS-1:0] mem1 [GRID_ROWS];
  logic [GRID_COLS-1:0] rd0_r, rd1_r, rd_cur;

  logic                 re, we, wsel;
  logic [RW-1:0]        raddr, waddr;
  logic [GRID_COLS-1:0] wdata;

  // Registers
  logic                        sel_r, sel_nxt;
  logic [RW-1:0]               clr_row_r, clr_row_nxt;
  logic [RW-1:0]               fetch_row_r, fetch_row_nxt;
  logic [RW-1:0]               cur_row_r, cur_row_nxt;
  logic [1:0]                  fill_cnt_r, fill_cnt_nxt;
  logic [CW-1:0]               bit_cnt_r, bit_cnt_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic [GRID_COLS-1:0]        win_up_r, win_mid_r, win_dn_r;
  logic [GRID_COLS-1:0]        sh_r, sh_nxt;
  logic [CNT_W-1:0]            live_r, live_nxt;
  logic                        res_cell_r, res_cell_nxt;
  logic [life_pkg::FUNC_W-1:0] func_r;
  logic [life_pkg::ROW_W-1:0]  row_r;
  logic [life_pkg::COL_W-1:0]  col_r;
  logic                        value_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_cell_r;
  logic [life_pkg::COUNT_W-1:0] out_count_r;

  logic                 accept, step_rd, out_load, in_grid;
  logic [CW-1:0]        col_ix;
  logic [GRID_COLS-1:0] next_row, cell_mod;
  logic [life_pkg::COUNT_W-1:0] live_sat;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign rd_cur   = sel_r ? rd1_r : rd0_r;
  assign col_ix   = CW'(col_r);
  assign in_grid  = (32'(in_row) < 32'(GRID_ROWS)) && (32'(in_col) < 32'(GRID_COLS));
  assign live_sat = (32'(live_r) > 32'(life_pkg::COUNT_MAX)) ? life_pkg::COUNT_MAX
                                                              : life_pkg::COUNT_W'(live_r);

  // Next generation of the middle window row, all columns in parallel
  always_comb begin
    int        lf;
    int        rt;
    logic [3:0] nb;
    next_row = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      lf = (c == 0) ? GRID_COLS - 1 : c - 1;
      rt = (c == GRID_COLS - 1) ? 0 : c + 1;
      nb = 4'(win_up_r[lf]) + 4'(win_up_r[c]) + 4'(win_up_r[rt])
         + 4'(win_mid_r[lf]) + 4'(win_mid_r[rt])
         + 4'(win_dn_r[lf]) + 4'(win_dn_r[c]) + 4'(win_dn_r[rt]);
      next_row[c] = (nb == 4'd3) || (win_mid_r[c] && (nb == 4'd2));
    end
  end

  // Row with the addressed cell replaced
  always_comb begin
    cell_mod         = rd_cur;
    cell_mod[col_ix] = value_r;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    clr_row_nxt   = clr_row_r;
    fetch_row_nxt = fetch_row_r;
    cur_row_nxt   = cur_row_r;
    fill_cnt_nxt  = fill_cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    sh_nxt        = sh_r;
    live_nxt      = live_r;
    res_cell_nxt  = res_cell_r;
    step_rd       = 1'b0;
    re            = 1'b0;
    raddr         = fetch_row_r;
    we            = 1'b0;
    wsel          = sel_r;
    waddr         = cur_row_r;
    wdata         = next_row;

    case (state_r)
      S_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_row_r;
        wdata       = '0;
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == RW'(GRID_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        raddr = RW'(in_row);
        if (accept) begin
          live_nxt     = '0;
          res_cell_nxt = 1'b0;
          if (in_func == life_pkg::FUNC_STEP) begin
            fetch_row_nxt = RW'(GRID_ROWS - 1);
            cur_row_nxt   = '0;
            fill_cnt_nxt  = '0;
            state_nxt     = S_FILL;
          end else if ((in_func == life_pkg::FUNC_WRITE || in_func == life_pkg::FUNC_READ)
                       && in_grid) begin
            re        = 1'b1;
            state_nxt = S_CELL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CELL: begin
        if (func_r == life_pkg::FUNC_WRITE) begin
          we    = 1'b1;
          waddr = RW'(row_r);
          wdata = cell_mod;
        end else begin
          res_cell_nxt = rd_cur[col_ix];
        end
        state_nxt = S_DONE;
      end
      S_FILL: begin
        // load rows last, 0 and 1 into the window
        if (fill_cnt_r != 2'd3) begin
          step_rd = 1'b1;
        end
        fill_cnt_nxt = fill_cnt_r + 1'b1;
        if (fill_cnt_r == 2'd3) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        // store the new row into the other buffer, fetch the next window row
        we          = 1'b1;
        wsel        = !sel_r;
        step_rd     = 1'b1;
        sh_nxt      = next_row;
        bit_cnt_nxt = '0;
        state_nxt   = S_COUNT;
      end
      S_COUNT: begin
        live_nxt    = live_r + CNT_W'(sh_r[0]);
        sh_nxt      = sh_r >> 1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == CW'(GRID_COLS - 1)) begin
          if (cur_row_r == RW'(GRID_ROWS - 1)) begin
            sel_nxt   = !sel_r;
            state_nxt = S_DONE;
          end else begin
            cur_row_nxt = cur_row_r + 1'b1;
            state_nxt   = S_CALC;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (step_rd) begin
      re            = 1'b1;
      fetch_row_nxt = (fetch_row_r == RW'(GRID_ROWS - 1)) ? '0 : fetch_row_r + 1'b1;
    end
    rd_pend_nxt = step_rd;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Memories: read data registered, one write port each
  always_ff @(posedge clk) begin
    if (we && !wsel) begin
      mem0[waddr] <= wdata;
    end
    if (re && !sel_r) begin
      rd0_r <= mem0[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we && wsel) begin
      mem1[waddr] <= wdata;
    end
    if (re && sel_r) begin
      rd1_r <= mem1[raddr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sel_r       <= 1'b0;
      clr_row_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      clr_row_r   <= clr_row_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    fetch_row_r <= fetch_row_nxt;
    cur_row_r   <= cur_row_nxt;
    fill_cnt_r  <= fill_cnt_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    sh_r        <= sh_nxt;
    live_r      <= live_nxt;
    res_cell_r  <= res_cell_nxt;
    if (accept) begin
      func_r  <= in_func;
      row_r   <= in_row;
      col_r   <= in_col;
      value_r <= in_value;
    end
    // window slides as each fetched row arrives
    if (rd_pend_r) begin
      win_up_r  <= win_mid_r;
      win_mid_r <= win_dn_r;
      win_dn_r  <= rd_cur;
    end
    if (out_load) begin
      out_cell_r  <= res_cell_r;
      out_count_r <= live_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_live_count = out_count_r;

endmodule

// ===== src/life_checker.sv =====
// ----------------------------------------------------------------------------
// life_checker
// Port-level checks for the toroidal Life grid, bound to the top level.
// ----------------------------------------------------------------------------
module life_checker #(
  parameter int GRID_ROWS = life_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = life_pkg::DEF_GRID_COLS
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [life_pkg::FUNC_W-1:0]  in_func,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_cell_value,
  input logic [life_pkg::COUNT_W-1:0] out_live_count
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int CAP   = (CELLS > 32'(life_pkg::COUNT_MAX)) ? 32'(life_pkg::COUNT_MAX)
                                                            : CELLS;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_value)
                                && $stable(out_live_count))
    else $error("result changed while stalled");

  // One transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // A result carries a cell value or a count, never both
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cell_value |-> out_live_count == '0)
    else $error("cell value and live count both set");

  // Live count never exceeds the grid
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_live_count) <= CAP)
    else $error("live count beyond grid size");

  // A step result needs its transaction accepted some time before
  a_step_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == life_pkg::FUNC_STEP |=> ##2 !in_ready)
    else $error("step finished too early");

endmodule

bind life_automaton_toroidal_grid life_checker #(
  .GRID_ROWS(GRID_ROWS),
  .GRID_COLS(GRID_COLS)
) u_life_checker (.*);
